[sv/nbpc_pkg.sv]
// Shared types and constants of the automaton policy checker.
`default_nettype none

package nbpc_pkg;

   // Widths that the request and response fields fix.
   localparam int PID_W      = 22;
   localparam int VALUE_W    = 32;
   localparam int NODE_FLD_W = 6;
   localparam int COUNT_W    = 7;
   localparam int NCOUNT_W   = 7;
   localparam int CSR_DATA_W = 22;
   localparam int CSR_IDX_W  = 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WATCHED_PID = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT  = 1'b1;

   // Request kinds.
   typedef enum logic [1:0] {
      REQ_CLEAR   = 2'd0,
      REQ_APPEND  = 2'd1,
      REQ_ARM     = 2'd2,
      REQ_OBSERVE = 2'd3
   } req_code_type;

   // Response status codes.
   typedef enum logic [2:0] {
      STS_DONE        = 3'd0,
      STS_NOT_WATCHED = 3'd1,
      STS_VIOLATION   = 3'd2,
      STS_TABLE_FULL  = 3'd3,
      STS_BAD_EDGE    = 3'd4
   } status_code_type;

   // One request.
   typedef struct packed {
      req_code_type              req_type;
      logic [PID_W-1:0]          process_id;
      logic signed [VALUE_W-1:0] match_value;
      logic [NODE_FLD_W-1:0]     edge_src;
      logic [NODE_FLD_W-1:0]     edge_dst;
      logic                      edge_is_epsilon;
   } req_payload_type;

   // One response.
   typedef struct packed {
      status_code_type    status;
      logic [COUNT_W-1:0] active_count;
   } rsp_payload_type;

endpackage

`default_nettype wire

[sv/nfa_bitset_policy_checker_top.sv]
// Top level of the automaton policy checker: sequencer, state sets and edge memory.
//
// Usage: requests enter on req_valid/req_stall/req_data and each produces exactly
// one response on rsp_valid/rsp_stall/rsp_data. A request is taken when valid is
// high and stall is low. Arm sweeps the edge memory to mark nodes with an incoming
// consuming edge, walks the nodes to build the start set, then repeats epsilon
// sweeps until one adds no node; an accepted observe makes one sweep over the
// consuming edges and then the same epsilon sweeps. The edge memory is read one
// entry per cycle. One request is worked on at a time; a finished response
// waits in the output register while the next request is already taken.
// Reset (synchronous, active high) empties the edge list, disarms the policy,
// clears the active set and sets watched_pid to 0 and node_count to 64; no
// clearing pass runs. While rsp_stall is high the response holds and the
// sequencer waits at its last step. Configuration writes on csr_we take effect
// at once and belong only in idle periods.
`default_nettype none

module nfa_bitset_policy_checker_top
   import nbpc_pkg::*;
#(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 256,
   parameter int ID_BITS   = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_payload_type       req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_payload_type            rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int CNT_W  = $clog2(MAX_NODES + 1);
   localparam int AW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int TW     = $clog2(MAX_EDGES + 1);
   // Edge entry layout: {epsilon, source, destination, match id}.
   localparam int EW     = ID_BITS + 2 * NODE_FLD_W + 1;
   localparam int DST_LO = ID_BITS;
   localparam int SRC_LO = ID_BITS + NODE_FLD_W;
   localparam int EPS_B  = ID_BITS + 2 * NODE_FLD_W;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_START, S_FIN} state_type;
   typedef enum logic [1:0] {PH_MARK, PH_MOVE, PH_EPS} phase_type;

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [PID_W-1:0]      watched_ff, watched_in;
   logic [NCOUNT_W-1:0]   ncount_ff, ncount_in;
   logic [TW-1:0]         total_ff, total_in;
   logic [TW-1:0]         idx_ff, idx_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  armed_ff, armed_in;
   logic                  changed_ff, changed_in;
   logic [MAX_NODES-1:0]  active_ff, active_in;
   logic [MAX_NODES-1:0]  next_ff, next_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic [ID_BITS-1:0]    obs_ff, obs_in;
   status_code_type       status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]      n_eff;
   logic                  ram_we;
   logic [EW-1:0]         ram_wdata;
   logic                  ram_re;
   logic [EW-1:0]         ram_rdata;
   logic                  r_eps;
   logic [NODE_FLD_W-1:0] r_src;
   logic [NODE_FLD_W-1:0] r_dst;
   logic [ID_BITS-1:0]    r_match;
   logic                  r_ok;
   logic [NODE_W-1:0]     r_src_i;
   logic [NODE_W-1:0]     r_dst_i;

   // Edge list storage.
   nbpc_ram #(
      .WIDTH(EW),
      .DEPTH(MAX_EDGES)
   ) u_edges (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(total_ff[AW-1:0]),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(idx_ff[AW-1:0]),
      .rd_data(ram_rdata)
   );

   // Node count clamped to 1..MAX_NODES.
   always_comb begin
      if (ncount_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(ncount_ff) > MAX_NODES) begin
         n_eff = CNT_W'(MAX_NODES);
      end else begin
         n_eff = CNT_W'(ncount_ff);
      end
   end

   // Fields of the edge read in the previous cycle.
   assign r_eps   = ram_rdata[EPS_B];
   assign r_src   = ram_rdata[SRC_LO +: NODE_FLD_W];
   assign r_dst   = ram_rdata[DST_LO +: NODE_FLD_W];
   assign r_match = ram_rdata[ID_BITS-1:0];
   assign r_ok    = (32'(r_src) < 32'(n_eff)) && (32'(r_dst) < 32'(n_eff));
   assign r_src_i = NODE_W'(r_src);
   assign r_dst_i = NODE_W'(r_dst);

   assign ram_wdata = {req_data.edge_is_epsilon, req_data.edge_src, req_data.edge_dst,
                       ID_BITS'(req_data.match_value)};

   // Sequencer and next-state logic.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      watched_in   = watched_ff;
      ncount_in    = ncount_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      rd_vld_in    = 1'b0;
      armed_in     = armed_ff;
      changed_in   = changed_ff;
      active_in    = active_ff;
      next_in      = next_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      obs_in       = obs_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      // Configuration writes.
      if (csr_we) begin
         if (csr_index == CSR_WATCHED_PID) begin
            watched_in = csr_wdata[PID_W-1:0];
         end
         if (csr_index == CSR_NODE_COUNT) begin
            ncount_in = csr_wdata[NCOUNT_W-1:0];
         end
      end

      // The taken response leaves the output register.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.req_type)
                  REQ_CLEAR: begin
                     total_in  = '0;
                     armed_in  = 1'b0;
                     active_in = '0;
                     cnt_in    = '0;
                     status_in = STS_DONE;
                     state_in  = S_FIN;
                  end
                  REQ_APPEND: begin
                     if ((32'(req_data.edge_src) >= 32'(n_eff)) ||
                         (32'(req_data.edge_dst) >= 32'(n_eff))) begin
                        status_in = STS_BAD_EDGE;
                     end else if (total_ff == TW'(MAX_EDGES)) begin
                        status_in = STS_TABLE_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        total_in  = total_ff + TW'(1);
                        status_in = STS_DONE;
                     end
                     state_in = S_FIN;
                  end
                  REQ_ARM: begin
                     armed_in = 1'b1;
                     next_in  = '0;
                     phase_in = PH_MARK;
                     idx_in   = '0;
                     state_in = S_SCAN;
                  end
                  REQ_OBSERVE: begin
                     if (!armed_ff || (req_data.process_id != watched_ff)) begin
                        status_in = STS_NOT_WATCHED;
                        state_in  = S_FIN;
                     end else begin
                        obs_in   = ID_BITS'(req_data.match_value);
                        next_in  = '0;
                        cnt_in   = '0;
                        phase_in = PH_MOVE;
                        idx_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Work on the edge whose read was issued last cycle.
            if (rd_vld_ff) begin
               unique case (phase_ff)
                  PH_MARK: begin
                     if (!r_eps && r_ok) begin
                        next_in[r_dst_i] = 1'b1;
                     end
                  end
                  PH_MOVE: begin
                     if (!r_eps && r_ok && (r_match == obs_ff) && active_ff[r_src_i] &&
                         !next_ff[r_dst_i]) begin
                        next_in[r_dst_i] = 1'b1;
                        cnt_in           = cnt_ff + CNT_W'(1);
                     end
                  end
                  PH_EPS: begin
                     if (r_eps && r_ok && active_ff[r_src_i] && !active_ff[r_dst_i]) begin
                        active_in[r_dst_i] = 1'b1;
                        cnt_in             = cnt_ff + CNT_W'(1);
                        changed_in         = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end

            // Issue the next read, or close the pass once the last edge is done.
            if (idx_ff < total_ff) begin
               ram_re    = 1'b1;
               idx_in    = idx_ff + TW'(1);
               rd_vld_in = 1'b1;
            end else if (!rd_vld_ff) begin
               unique case (phase_ff)
                  PH_MARK: begin
                     active_in = '0;
                     cnt_in    = '0;
                     k_in      = '0;
                     state_in  = S_START;
                  end
                  PH_MOVE: begin
                     active_in  = next_ff;
                     phase_in   = PH_EPS;
                     idx_in     = '0;
                     changed_in = 1'b0;
                  end
                  PH_EPS: begin
                     if (changed_ff) begin
                        idx_in     = '0;
                        changed_in = 1'b0;
                     end else begin
                        status_in = (cnt_ff == '0) ? STS_VIOLATION : STS_DONE;
                        state_in  = S_FIN;
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end

         S_START: begin
            // Nodes without an incoming consuming edge start active.
            if (32'(k_ff) < 32'(n_eff)) begin
               if (!next_ff[k_ff[NODE_W-1:0]]) begin
                  active_in[k_ff[NODE_W-1:0]] = 1'b1;
                  cnt_in                      = cnt_ff + CNT_W'(1);
               end
               k_in = k_ff + CNT_W'(1);
            end else begin
               phase_in   = PH_EPS;
               idx_in     = '0;
               changed_in = 1'b0;
               state_in   = S_SCAN;
            end
         end

         S_FIN: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = status_ff;
               rsp_data_in.active_count = COUNT_W'(cnt_ff);
               state_in                 = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_MARK;
         watched_ff   <= '0;
         ncount_ff    <= NCOUNT_W'(64);
         total_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         armed_ff     <= 1'b0;
         changed_ff   <= 1'b0;
         active_ff    <= '0;
         next_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         watched_ff   <= watched_in;
         ncount_ff    <= ncount_in;
         total_ff     <= total_in;
         rd_vld_ff    <= rd_vld_in;
         armed_ff     <= armed_in;
         changed_ff   <= changed_in;
         active_ff    <= active_in;
         next_ff      <= next_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      k_ff        <= k_in;
      obs_ff      <= obs_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Requests are held off during reset and while one is being worked on.
   assign req_stall = reset || (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[sv/nbpc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module nbpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
